// ===== rtl/motor_position_pid_step_macros.svh =====
// Assertion macros for the motor position PID step block.
// Included by the top level; expects clk and rst_n in scope.
`ifndef MOTOR_POSITION_PID_STEP_MACROS_SVH
`define MOTOR_POSITION_PID_STEP_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define MPPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define MPPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mpps_pkg.sv =====
// Shared types and constants for the motor position PID step block.
// No dependencies; mpps_cfg, mpps_jog and the top level refer to it by scoped names.
`default_nettype none

package mpps_pkg;

  localparam int POT_W        = 12;
  localparam int POS_W        = 24;
  localparam int ERR_W        = 25;
  localparam int ACC_W        = 32;
  localparam int GAIN_W       = 16;
  localparam int DUTY_W       = 8;
  localparam int MCAND_W      = 45;
  localparam int PROD_W       = MCAND_W + GAIN_W;
  localparam int GAIN_SHIFT   = 17;
  localparam int ACCS_W       = PROD_W - GAIN_SHIFT + 1;
  localparam int DEG_W        = 9;
  localparam int POT_DEADBAND = 10;
  localparam int POT_FULL     = 4095;
  localparam int DUTY_MAX     = 255;
  localparam int MID_SHIFT    = 9;

  localparam int IN_TDATA_W   = 64;
  localparam int OUT_DATA_W   = 11;
  localparam int OUT_TDATA_W  = 16;
  localparam int CFG_ADDR_W   = 5;
  localparam int CFG_DATA_W   = 32;

  localparam logic [GAIN_W-1:0] KP_RESET       = 16'd256;
  localparam logic [DUTY_W-1:0] MIN_DUTY_RESET = 8'd50;

  typedef enum logic [2:0] {
    REG_MANUAL   = 3'd0,
    REG_KP       = 3'd1,
    REG_KI       = 3'd2,
    REG_KD       = 3'd3,
    REG_MIN_DUTY = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic              manual_mode;
    logic [GAIN_W-1:0] kp_gain;
    logic [GAIN_W-1:0] ki_gain;
    logic [GAIN_W-1:0] kd_gain;
    logic [DUTY_W-1:0] min_duty;
  } cfg_regs_t;

  typedef struct packed {
    logic load_step;
    logic add_step;
  } jog_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_JOG_A,
    S_JOG_B,
    S_ERR,
    S_DIF,
    S_KI,
    S_KI_W,
    S_KD,
    S_KD_W,
    S_KP,
    S_KP_W,
    S_ACC,
    S_DRV,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/mpps_cfg.sv =====
// APB-style register file for gains, manual mode and minimum duty.
// Depends on mpps_pkg.
`default_nettype none

module mpps_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mpps_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [mpps_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [mpps_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output mpps_pkg::cfg_regs_t                   regs
);

  mpps_pkg::cfg_regs_t regs_r;
  mpps_pkg::cfg_idx_t  idx;
  logic                wr_en;

  assign idx    = mpps_pkg::cfg_idx_t'(paddr[mpps_pkg::CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign regs   = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.manual_mode <= 1'b0;
      regs_r.kp_gain     <= mpps_pkg::KP_RESET;
      regs_r.ki_gain     <= '0;
      regs_r.kd_gain     <= '0;
      regs_r.min_duty    <= mpps_pkg::MIN_DUTY_RESET;
    end else if (wr_en) begin
      unique case (idx)
        mpps_pkg::REG_MANUAL:   regs_r.manual_mode <= pwdata[0];
        mpps_pkg::REG_KP:       regs_r.kp_gain     <= pwdata[mpps_pkg::GAIN_W-1:0];
        mpps_pkg::REG_KI:       regs_r.ki_gain     <= pwdata[mpps_pkg::GAIN_W-1:0];
        mpps_pkg::REG_KD:       regs_r.kd_gain     <= pwdata[mpps_pkg::GAIN_W-1:0];
        mpps_pkg::REG_MIN_DUTY: regs_r.min_duty    <= pwdata[mpps_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      mpps_pkg::REG_MANUAL:   prdata[0] = regs_r.manual_mode;
      mpps_pkg::REG_KP:       prdata[mpps_pkg::GAIN_W-1:0] = regs_r.kp_gain;
      mpps_pkg::REG_KI:       prdata[mpps_pkg::GAIN_W-1:0] = regs_r.ki_gain;
      mpps_pkg::REG_KD:       prdata[mpps_pkg::GAIN_W-1:0] = regs_r.kd_gain;
      mpps_pkg::REG_MIN_DUTY: prdata[mpps_pkg::DUTY_W-1:0] = regs_r.min_duty;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mpps_smul.sv =====
// Bit-serial shift-add multiplier: unsigned multiplier times signed multiplicand,
// one multiplier bit per cycle. Depends on nothing but its parameters.
`default_nettype none

module mpps_smul #(
  parameter int MCAND_W = 45,
  parameter int MULT_W  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic        [MULT_W-1:0]          multiplier,
  input  wire logic signed [MCAND_W-1:0]         mcand,
  output logic                                   done,
  output logic signed      [MCAND_W+MULT_W-1:0]  product
);

  localparam int CNT_W = $clog2(MULT_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MULT_W - 1);

  logic signed [MCAND_W:0]   hi_r;
  logic        [MULT_W-1:0]  lo_r;
  logic signed [MCAND_W-1:0] mc_r;
  logic        [CNT_W-1:0]   cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic signed [MCAND_W:0]   sum;

  // Add the multiplicand when the current multiplier bit is set.
  assign sum     = lo_r[0] ? hi_r + (MCAND_W+1)'(mc_r) : hi_r;
  assign product = $signed({hi_r[MCAND_W-1:0], lo_r});
  assign done    = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi_r <= '0;
      lo_r <= multiplier;
      mc_r <= mcand;
    end else if (busy_r) begin
      // Shift the partial product right by one, arithmetic.
      hi_r <= {sum[MCAND_W], sum[MCAND_W:1]};
      lo_r <= {sum[0], lo_r[MULT_W-1:1]};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mpps_jog.sv =====
// Target register with load and potentiometer jog filter.
// Depends on mpps_pkg.
`default_nettype none

module mpps_jog #(
  parameter int POT_STABLE_TICKS = 5,
  parameter int FRAC_BITS        = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire mpps_pkg::jog_ctl_t                  ctl,
  input  wire logic                                manual_mode,
  input  wire logic        [mpps_pkg::POT_W-1:0]   pot_sample,
  input  wire logic                                load_target,
  input  wire logic signed [mpps_pkg::POS_W-1:0]   new_target,
  output logic signed      [mpps_pkg::POS_W-1:0]   target,
  output logic                                     settle_clr
);

  localparam int PC_W = $clog2(POT_STABLE_TICKS + 1);
  localparam int TS_W = mpps_pkg::POS_W + 2;
  localparam int P_W  = mpps_pkg::POT_W + 9;

  logic signed [mpps_pkg::POS_W-1:0] target_r;
  logic [mpps_pkg::POT_W-1:0]        pot_ref_r;
  logic [PC_W-1:0]                   pot_cnt_r;
  logic                              fire_r;
  logic                              clr_r;
  logic [mpps_pkg::DEG_W-1:0]        deg_mag_r;
  logic                              deg_neg_r;

  logic signed [mpps_pkg::POT_W:0]   diff;
  logic [mpps_pkg::POT_W-1:0]        ad;
  logic [PC_W-1:0]                   cnt_nxt;
  logic                              fire_nxt;
  logic [P_W-1:0]                    p;
  logic [mpps_pkg::DEG_W-1:0]        t;
  logic [mpps_pkg::POT_W:0]          s;
  logic [mpps_pkg::DEG_W-1:0]        q;
  logic [TS_W-1:0]                   step_mag;
  logic signed [TS_W-1:0]            tsum;
  logic signed [mpps_pkg::POS_W-1:0] tsat;

  assign target     = target_r;
  assign settle_clr = clr_r;

  always_comb begin
    diff = $signed({1'b0, pot_sample}) - $signed({1'b0, pot_ref_r});
    ad   = diff[mpps_pkg::POT_W] ? mpps_pkg::POT_W'(-diff) : diff[mpps_pkg::POT_W-1:0];
    if (ad < mpps_pkg::POT_W'(mpps_pkg::POT_DEADBAND)) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = pot_cnt_r + PC_W'(1);
    end
    fire_nxt = (cnt_nxt == PC_W'(POT_STABLE_TICKS));
    // |diff| * 360 / 4095: take apart p = 4096*t + r, then one correction.
    p = (P_W'(ad) << 8) + (P_W'(ad) << 6) + (P_W'(ad) << 5) + (P_W'(ad) << 3);
    t = p[P_W-1:mpps_pkg::POT_W];
    s = (mpps_pkg::POT_W+1)'(t) + (mpps_pkg::POT_W+1)'(p[mpps_pkg::POT_W-1:0]);
    q = t + mpps_pkg::DEG_W'(s >= (mpps_pkg::POT_W+1)'(mpps_pkg::POT_FULL));
  end

  always_comb begin
    step_mag = TS_W'(deg_mag_r) << FRAC_BITS;
    tsum     = TS_W'(target_r) + (deg_neg_r ? -$signed(step_mag) : $signed(step_mag));
    if (tsum[TS_W-1:mpps_pkg::POS_W-1] != {(TS_W-mpps_pkg::POS_W+1){tsum[TS_W-1]}}) begin
      tsat = tsum[TS_W-1] ? {1'b1, {(mpps_pkg::POS_W-1){1'b0}}}
                          : {1'b0, {(mpps_pkg::POS_W-1){1'b1}}};
    end else begin
      tsat = tsum[mpps_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= '0;
      pot_ref_r <= '0;
      pot_cnt_r <= '0;
      fire_r    <= 1'b0;
      clr_r     <= 1'b0;
    end else begin
      if (ctl.load_step) begin
        if (load_target) begin
          target_r <= new_target;
        end
        if (manual_mode) begin
          pot_cnt_r <= fire_nxt ? '0 : cnt_nxt;
        end
        fire_r <= manual_mode && fire_nxt;
        clr_r  <= load_target || (manual_mode && fire_nxt);
      end
      if (ctl.add_step && fire_r) begin
        target_r  <= tsat;
        pot_ref_r <= pot_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_step) begin
      deg_mag_r <= q;
      deg_neg_r <= diff[mpps_pkg::POT_W];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/motor_position_pid_step.sv =====
// Top level of the motor position PID step block: sequencer, PID datapath,
// drive stage and output register. Uses mpps_pkg, mpps_cfg, mpps_jog, mpps_smul.
//
//   Channel  Ports                        Word contents (low bit first)
//   in       in_tvalid/in_tready/tdata    pot_sample, position_q8, new_target_q8
//                                         (tuser: load_target)
//   out      out_tvalid/out_tready/tdata  duty, forward, backward, settled
//   cfg      psel/penable/pwrite/paddr    manual_mode, kp, ki, kd, min_duty
//
// One word is worked on at a time. A tick that runs the PID goes through the jog
// steps, the error and difference steps, three multiplier passes (start,
// bit-serial shifts, done) and the accumulate, drive and output steps. A tick
// that finds the block settled goes from the jog steps straight to the output
// step. The input reopens in the cycle after the output register is loaded.
// rst_n is synchronous; the block comes up settled with the motor stopped.
// A new word is taken while the previous result still waits in the output
// register; a stalled output holds the sequencer in its last state until the
// register frees up.
`default_nettype none

module motor_position_pid_step #(
  parameter int POT_STABLE_TICKS = 5,
  parameter int SETTLE_TICKS     = 2,
  parameter int FRAC_BITS        = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // in_tdata: pot_sample[11:0], position_q8[35:12], new_target_q8[59:36], zeros
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [mpps_pkg::IN_TDATA_W-1:0]       in_tdata,
  // in_tuser: load_target
  input  wire logic                                  in_tuser,
  // out_tdata: duty[7:0], forward[8], backward[9], settled[10], zeros
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic      [mpps_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [mpps_pkg::CFG_ADDR_W-1:0]       paddr,
  input  wire logic [mpps_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic      [mpps_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                       pready
);

`include "motor_position_pid_step_macros.svh"

  localparam int SC_W  = $clog2(SETTLE_TICKS + 1);
  localparam int D_W   = mpps_pkg::ERR_W + 1;
  localparam int C_W   = mpps_pkg::ERR_W + 2;
  localparam int ERR_W = mpps_pkg::ERR_W;
  localparam int ACC_W = mpps_pkg::ACC_W;
  localparam int MC_W  = mpps_pkg::MCAND_W;
  localparam logic signed [ERR_W-1:0] HALF_Q = ERR_W'(1 << (FRAC_BITS - 1));

  // Configuration registers.
  mpps_pkg::cfg_regs_t regs;

  mpps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs)
  );

  // Sequencer state and latched input word.
  mpps_pkg::state_t state_r, state_nxt;

  logic [mpps_pkg::POT_W-1:0]        pot_r;
  logic signed [mpps_pkg::POS_W-1:0] pos_r;
  logic signed [mpps_pkg::POS_W-1:0] newt_r;
  logic                              load_r;

  // PID state.
  logic signed [ERR_W-1:0] err1_r, err2_r, e_r;
  logic signed [ACC_W-1:0] accum_r;
  logic [SC_W-1:0]         settle_cnt_r;
  logic                    settled_r;
  logic                    near_r;
  logic signed [D_W-1:0]   a_r, b_r;
  logic signed [C_W-1:0]   c_r;
  logic signed [MC_W-1:0]  inner_r;

  // Drive outputs and output register.
  logic [mpps_pkg::DUTY_W-1:0]     duty_r;
  logic                            fwd_r, bwd_r;
  logic                            out_tvalid_r;
  logic [mpps_pkg::OUT_DATA_W-1:0] out_data_r;

  // Jog unit.
  mpps_pkg::jog_ctl_t                jog_ctl;
  logic signed [mpps_pkg::POS_W-1:0] target;
  logic                              jog_clr;

  mpps_jog #(
    .POT_STABLE_TICKS (POT_STABLE_TICKS),
    .FRAC_BITS        (FRAC_BITS)
  ) u_jog (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (jog_ctl),
    .manual_mode (regs.manual_mode),
    .pot_sample  (pot_r),
    .load_target (load_r),
    .new_target  (newt_r),
    .target      (target),
    .settle_clr  (jog_clr)
  );

  // Shared serial multiplier.
  logic                                  mul_start;
  logic [mpps_pkg::GAIN_W-1:0]           mul_gain;
  logic signed [MC_W-1:0]                mul_mcand;
  logic                                  mul_done;
  logic signed [mpps_pkg::PROD_W-1:0]    mul_prod;

  mpps_smul #(
    .MCAND_W (MC_W),
    .MULT_W  (mpps_pkg::GAIN_W)
  ) u_smul (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (mul_start),
    .multiplier (mul_gain),
    .mcand      (mul_mcand),
    .done       (mul_done),
    .product    (mul_prod)
  );

  logic                    in_acc;
  logic                    out_free;
  logic signed [ERR_W-1:0] e_nxt;
  logic signed [mpps_pkg::ACCS_W-1:0] acc_sum;
  logic signed [ACC_W-1:0] acc_sat;
  logic [SC_W-1:0]         sc_nxt;
  logic [ACC_W-1:0]        mag;
  logic [ACC_W-1:0]        mag_int;
  logic [mpps_pkg::DUTY_W-1:0] duty_nxt;

  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = mpps_pkg::OUT_TDATA_W'(out_data_r);

  // Next state, handshake and unit controls.
  always_comb begin
    state_nxt         = state_r;
    in_tready         = 1'b0;
    jog_ctl.load_step = 1'b0;
    jog_ctl.add_step  = 1'b0;
    mul_start         = 1'b0;
    mul_gain          = regs.kp_gain;
    mul_mcand         = inner_r;
    unique case (state_r)
      mpps_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = mpps_pkg::S_JOG_A;
        end
      end
      mpps_pkg::S_JOG_A: begin
        jog_ctl.load_step = 1'b1;
        state_nxt         = mpps_pkg::S_JOG_B;
      end
      mpps_pkg::S_JOG_B: begin
        jog_ctl.add_step = 1'b1;
        // Skip the PID when the block stays settled through this tick.
        state_nxt = (settled_r && !jog_clr) ? mpps_pkg::S_OUT : mpps_pkg::S_ERR;
      end
      mpps_pkg::S_ERR: state_nxt = mpps_pkg::S_DIF;
      mpps_pkg::S_DIF: state_nxt = mpps_pkg::S_KI;
      mpps_pkg::S_KI: begin
        mul_start = 1'b1;
        mul_gain  = regs.ki_gain;
        mul_mcand = MC_W'(b_r);
        state_nxt = mpps_pkg::S_KI_W;
      end
      mpps_pkg::S_KI_W: if (mul_done) state_nxt = mpps_pkg::S_KD;
      mpps_pkg::S_KD: begin
        mul_start = 1'b1;
        mul_gain  = regs.kd_gain;
        mul_mcand = MC_W'(c_r) <<< 1;
        state_nxt = mpps_pkg::S_KD_W;
      end
      mpps_pkg::S_KD_W: if (mul_done) state_nxt = mpps_pkg::S_KP;
      mpps_pkg::S_KP: begin
        mul_start = 1'b1;
        state_nxt = mpps_pkg::S_KP_W;
      end
      mpps_pkg::S_KP_W: if (mul_done) state_nxt = mpps_pkg::S_ACC;
      mpps_pkg::S_ACC:  state_nxt = mpps_pkg::S_DRV;
      mpps_pkg::S_DRV:  state_nxt = mpps_pkg::S_OUT;
      mpps_pkg::S_OUT:  if (out_free) state_nxt = mpps_pkg::S_IDLE;
      default:          state_nxt = mpps_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpps_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath arithmetic for the error, accumulator and drive steps.
  always_comb begin
    e_nxt   = ERR_W'(target) - ERR_W'(pos_r);
    // Floor by 2^17 is the top of the product; add and clamp to 32 bits.
    acc_sum = mpps_pkg::ACCS_W'(accum_r)
            + mpps_pkg::ACCS_W'($signed(mul_prod[mpps_pkg::PROD_W-1:mpps_pkg::GAIN_SHIFT]));
    if (acc_sum[mpps_pkg::ACCS_W-1:ACC_W-1]
        != {(mpps_pkg::ACCS_W-ACC_W+1){acc_sum[mpps_pkg::ACCS_W-1]}}) begin
      acc_sat = acc_sum[mpps_pkg::ACCS_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                            : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
    sc_nxt  = near_r ? settle_cnt_r + SC_W'(1) : '0;
    mag     = accum_r[ACC_W-1] ? ACC_W'(0) - accum_r : accum_r;
    mag_int = mag >> FRAC_BITS;
    if (mag_int < ACC_W'(regs.min_duty)) begin
      duty_nxt = regs.min_duty;
    end else if (mag_int > ACC_W'(mpps_pkg::DUTY_MAX)) begin
      duty_nxt = mpps_pkg::DUTY_W'(mpps_pkg::DUTY_MAX);
    end else begin
      duty_nxt = mag_int[mpps_pkg::DUTY_W-1:0];
    end
  end

  // Control and PID state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err1_r       <= '0;
      err2_r       <= '0;
      accum_r      <= '0;
      settle_cnt_r <= '0;
      settled_r    <= 1'b1;
      duty_r       <= '0;
      fwd_r        <= 1'b0;
      bwd_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      unique case (state_r)
        mpps_pkg::S_JOG_B: begin
          if (jog_clr) begin
            settled_r <= 1'b0;
          end
        end
        mpps_pkg::S_ACC: begin
          err2_r <= err1_r;
          err1_r <= e_r;
          // Enough quiet ticks: mark settled and drop the drive.
          if (sc_nxt == SC_W'(SETTLE_TICKS)) begin
            settled_r    <= 1'b1;
            accum_r      <= '0;
            settle_cnt_r <= '0;
          end else begin
            accum_r      <= acc_sat;
            settle_cnt_r <= sc_nxt;
          end
        end
        mpps_pkg::S_DRV: begin
          if (accum_r == '0) begin
            duty_r <= '0;
            fwd_r  <= 1'b0;
            bwd_r  <= 1'b0;
          end else begin
            duty_r <= duty_nxt;
            fwd_r  <= !accum_r[ACC_W-1];
            bwd_r  <= accum_r[ACC_W-1];
          end
        end
        default: ;
      endcase
      if (state_r == mpps_pkg::S_OUT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers: input latch, difference terms, midpoint sum, result word.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pot_r  <= in_tdata[mpps_pkg::POT_W-1:0];
      pos_r  <= in_tdata[mpps_pkg::POT_W+mpps_pkg::POS_W-1:mpps_pkg::POT_W];
      newt_r <= in_tdata[mpps_pkg::POT_W+2*mpps_pkg::POS_W-1:
                         mpps_pkg::POT_W+mpps_pkg::POS_W];
      load_r <= in_tuser;
    end
    if (state_r == mpps_pkg::S_ERR) begin
      e_r <= e_nxt;
    end
    if (state_r == mpps_pkg::S_DIF) begin
      a_r    <= D_W'(e_r) - D_W'(err1_r);
      b_r    <= D_W'(e_r) + D_W'(err1_r);
      c_r    <= C_W'(e_r) - (C_W'(err1_r) <<< 1) + C_W'(err2_r);
      near_r <= (e_r > -HALF_Q) && (e_r < HALF_Q);
    end
    // inner = 512*(e - e1) + ki*(e + e1) + 2*kd*(e - 2*e1 + e2)
    if (state_r == mpps_pkg::S_KI_W && mul_done) begin
      inner_r <= (MC_W'(a_r) <<< mpps_pkg::MID_SHIFT) + $signed(mul_prod[MC_W-1:0]);
    end
    if (state_r == mpps_pkg::S_KD_W && mul_done) begin
      inner_r <= inner_r + $signed(mul_prod[MC_W-1:0]);
    end
    if (state_r == mpps_pkg::S_OUT && out_free) begin
      out_data_r <= {settled_r, bwd_r, fwd_r, duty_r};
    end
  end

  `MPPS_ASSERT_NOW(a_settled_accum_zero, settled_r, accum_r == '0, "accumulator live while settled")
  `MPPS_ASSERT_NOW(a_dir_exclusive, fwd_r, !bwd_r, "forward and backward both driven")
  `MPPS_ASSERT_NOW(a_stop_duty_zero, !fwd_r && !bwd_r, duty_r == '0, "duty without direction")
  `MPPS_ASSERT_NEXT(a_accept_start, in_tvalid && in_tready, state_r == mpps_pkg::S_JOG_A, "word not started")

endmodule

`default_nettype wire

// ===== bench/motor_position_pid_step_checker.sv =====
// Checker for motor_position_pid_step: watches the in, out and cfg ports, predicts each
// drive word and compares it field by field with what the block returns.
// Depends on mpps_pkg for widths, reset values and register indexes.
module motor_position_pid_step_checker
  import mpps_pkg::*;
#(
  parameter int POT_STABLE_TICKS = 5,
  parameter int SETTLE_TICKS     = 2,
  parameter int FRAC_BITS        = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  input  logic                   pready,
  output int                     fault_count,
  output int                     words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int    JOG_SPAN_DEG = 360;
  localparam longint HALF_DEG    = longint'(1) << (FRAC_BITS - 1);
  localparam longint ACC_TOP     = (longint'(1) << (ACC_W - 1)) - 1;
  localparam longint ACC_BOTTOM  = -(longint'(1) << (ACC_W - 1));
  localparam longint POS_TOP     = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint POS_BOTTOM  = -(longint'(1) << (POS_W - 1));

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              forward;
    logic              backward;
    logic              settled;
  } drive_word_t;

  cfg_regs_t               regs;
  logic signed [POS_W-1:0] target_q;
  logic [POT_W-1:0]        knob_ref;
  int                      knob_run;
  logic signed [ERR_W-1:0] err_d1;
  logic signed [ERR_W-1:0] err_d2;
  logic signed [ACC_W-1:0] accum;
  int                      settle_run;
  logic                    settled;
  drive_word_t             held;
  drive_word_t             drive_words_due[$];
  drive_word_t             got;
  drive_word_t             want;
  int                      faults = 0;

  // One sample tick: target load, pot jog filter, then the PID step if not settled.
  task automatic predict_tick(input logic [POT_W-1:0] pot, input logic signed [POS_W-1:0] pos,
                              input logic load, input logic signed [POS_W-1:0] new_target);
    int     diff;
    int     deg;
    longint e;
    longint c0;
    longint c1;
    longint c2;
    longint inner;
    longint sum;
    longint mag;
    longint moved;
    if (load) begin
      target_q = new_target;
      settled  = 1'b0;
    end
    if (regs.manual_mode) begin
      diff = int'(pot) - int'(knob_ref);
      if (diff < POT_DEADBAND && diff > -POT_DEADBAND) knob_run = 0;
      else knob_run++;
      if (knob_run == POT_STABLE_TICKS) begin
        deg      = diff * JOG_SPAN_DEG / POT_FULL;
        knob_run = 0;
        settled  = 1'b0;
        moved    = longint'(target_q) + longint'(deg) * (longint'(1) << FRAC_BITS);
        if (moved > POS_TOP) moved = POS_TOP;
        if (moved < POS_BOTTOM) moved = POS_BOTTOM;
        target_q = moved[POS_W-1:0];
        knob_ref = pot;
      end
    end
    if (!settled) begin
      e     = longint'(target_q) - longint'(pos);
      c0    = (longint'(1) << MID_SHIFT) + 2 * longint'(regs.kd_gain) + longint'(regs.ki_gain);
      c1    = longint'(regs.ki_gain) - (longint'(1) << MID_SHIFT) - 4 * longint'(regs.kd_gain);
      c2    = 2 * longint'(regs.kd_gain);
      inner = c0 * e + c1 * longint'(err_d1) + c2 * longint'(err_d2);
      // arithmetic shift of a signed value floors
      sum   = longint'(accum) + ((inner * longint'(regs.kp_gain)) >>> GAIN_SHIFT);
      if (sum > ACC_TOP) sum = ACC_TOP;
      if (sum < ACC_BOTTOM) sum = ACC_BOTTOM;
      accum  = sum[ACC_W-1:0];
      err_d2 = err_d1;
      err_d1 = e[ERR_W-1:0];
      if (e > -HALF_DEG && e < HALF_DEG) settle_run++;
      else settle_run = 0;
      if (settle_run == SETTLE_TICKS) begin
        settled    = 1'b1;
        accum      = '0;
        settle_run = 0;
      end
      if (accum == 0) begin
        held = '0;
      end else begin
        mag           = (accum > 0) ? longint'(accum) : -longint'(accum);
        held.forward  = accum > 0;
        held.backward = accum < 0;
        mag           = mag >> FRAC_BITS;
        if (mag < longint'(regs.min_duty)) mag = longint'(regs.min_duty);
        if (mag > DUTY_MAX) mag = DUTY_MAX;
        held.duty = mag[DUTY_W-1:0];
      end
    end
    held.settled = settled;
    drive_words_due.push_back(held);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs = '{manual_mode: 1'b0, kp_gain: KP_RESET, ki_gain: '0, kd_gain: '0,
               min_duty: MIN_DUTY_RESET};
      target_q   = '0;
      knob_ref   = '0;
      knob_run   = 0;
      err_d1     = '0;
      err_d2     = '0;
      accum      = '0;
      settle_run = 0;
      settled    = 1'b1;
      held       = '0;
      drive_words_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_idx_t'(paddr[CFG_ADDR_W-1:2]))
          REG_MANUAL:   regs.manual_mode = pwdata[0];
          REG_KP:       regs.kp_gain     = pwdata[GAIN_W-1:0];
          REG_KI:       regs.ki_gain     = pwdata[GAIN_W-1:0];
          REG_KD:       regs.kd_gain     = pwdata[GAIN_W-1:0];
          REG_MIN_DUTY: regs.min_duty    = pwdata[DUTY_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = '{duty: out_tdata[DUTY_W-1:0], forward: out_tdata[DUTY_W],
                backward: out_tdata[DUTY_W+1], settled: out_tdata[DUTY_W+2]};
        if (drive_words_due.size() == 0) begin
          $error("drive word with none predicted: duty %0d", got.duty);
          faults++;
        end else begin
          want = drive_words_due.pop_front();
          if (got.duty !== want.duty) begin
            $error("duty mismatch: expected %0d, actual %0d", want.duty, got.duty);
            faults++;
          end
          if (got.forward !== want.forward) begin
            $error("forward mismatch: expected %0d, actual %0d", want.forward, got.forward);
            faults++;
          end
          if (got.backward !== want.backward) begin
            $error("backward mismatch: expected %0d, actual %0d", want.backward, got.backward);
            faults++;
          end
          if (got.settled !== want.settled) begin
            $error("settled mismatch: expected %0d, actual %0d", want.settled, got.settled);
            faults++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_tick(in_tdata[POT_W-1:0], in_tdata[POT_W+POS_W-1:POT_W], in_tuser,
                     in_tdata[POT_W+2*POS_W-1:POT_W+POS_W]);
      end
    end
    words_due   <= drive_words_due.size();
    fault_count <= faults;
  end

endmodule

// ===== bench/motor_position_pid_step_test.sv =====
// Top of the motor_position_pid_step bench: clock, reset, tick stimulus, APB register
// writes and the verdict. Depends on mpps_pkg, the block and motor_position_pid_step_checker.
module motor_position_pid_step_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mpps_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 7;
  // Allow a long tail after the last word.
  localparam int TAIL_CYCLES  = 80;
  // The bound sits far above what a slow run needs.
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_WORDS = 1600;
  localparam int SETTINGS     = 8;
  localparam int SPARE_REG_LO = 5;
  localparam int SPARE_REG_HI = 7;
  localparam int POS_TOP      = 8388607;
  localparam int POS_BOTTOM   = -8388608;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  paddr = '0;
  logic [CFG_DATA_W-1:0]  pwdata = '0;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;

  int fault_count;
  int words_due;
  int words_sent = 0;
  int send_idle  = 9;   // percent of cycles the sender holds back
  int recv_idle  = 53;  // percent of cycles the receiver stalls
  int aim        = 0;   // last target loaded by the stimulus
  int knob       = 0;   // pot value the stimulus is holding

  motor_position_pid_step dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // pot_sample, position_q8, new_target_q8, zeros
    .in_tuser  (in_tuser),   // load_target
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // duty, forward, backward, settled, zeros
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  motor_position_pid_step_checker pid_watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fault_count(fault_count),
    .words_due  (words_due)
  );

  always #CLK_HALF clk = ~clk;

  // Stall the result side at random; a single assignment per edge.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Cut off a hung run.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic int clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return int'(lo);
    if (v > hi) return int'(hi);
    return int'(v);
  endfunction

  // Offer one tick word, with random hold-off first, and return at the edge that takes it.
  // Valid stays high into the next word when no hold-off is drawn.
  task automatic send_word(input int pot, input int pos, input bit load, input int new_target);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, new_target[POS_W-1:0], pos[POS_W-1:0], pot[POT_W-1:0]};
    in_tuser  <= load;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // Drop valid, hold until every predicted word has come back, then let the block go quiet.
  // The first edge is waited out so the count includes a word taken on this edge.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; junk above the field checks masking.
  task automatic write_reg(input logic [2:0] idx, input int unsigned value, input int width);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom << width) | value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_setting(input int unsigned manual, input int unsigned kp,
                               input int unsigned ki, input int unsigned kd,
                               input int unsigned min_duty);
    write_reg(REG_MANUAL, manual, 1);
    write_reg(REG_KP, kp, GAIN_W);
    write_reg(REG_KI, ki, GAIN_W);
    write_reg(REG_KD, kd, GAIN_W);
    write_reg(REG_MIN_DUTY, min_duty, DUTY_W);
  endtask

  // Mostly target moves that close in and settle, some pot jogs (held or cut short),
  // and some words with every field random.
  task automatic run_random(input int count);
    int          quota;
    int          pause_at;
    bit          paused;
    int          steps;
    int          span;
    int          off;
    int unsigned roll;
    quota    = words_sent + count;
    pause_at = words_sent + $urandom_range(count - 1);
    paused   = 1'b0;
    while (words_sent < quota) begin
      if (!paused && words_sent >= pause_at) begin
        paused = 1'b1;
        wait_drained();
      end
      roll = $urandom_range(99);
      if (roll < 12) begin
        send_word($urandom, $urandom, 1'($urandom), $urandom);
      end else if (roll < 30) begin
        // Jog: move the pot and hold it; short holds must not move the target.
        knob  = $urandom_range(POT_FULL);
        steps = $urandom_range(9, 1);
        repeat (steps) begin
          send_word(clip(knob + int'($urandom_range(8)) - 4, 0, POT_FULL),
                    clip(longint'(aim) + int'($urandom_range(400)) - 200,
                         POS_BOTTOM, POS_TOP),
                    1'b0, $urandom);
        end
      end else begin
        // Load a target, then step the position toward it until it settles.
        case ($urandom_range(9))
          0:       aim = POS_TOP - int'($urandom_range(4096));
          1:       aim = POS_BOTTOM + int'($urandom_range(4096));
          default: aim = int'($urandom_range(1 << 18)) - (1 << 17);
        endcase
        case ($urandom_range(3))
          0:       span = 255;
          1:       span = 4095;
          2:       span = 65535;
          default: span = 1048575;
        endcase
        off   = int'($urandom_range(2 * span)) - span;
        steps = $urandom_range(24, 3);
        for (int i = 0; i < steps; i++) begin
          send_word(knob, clip(longint'(aim) + off, POS_BOTTOM, POS_TOP), i == 0, aim);
          off = off / 2 + int'($urandom_range(64)) - 32;
        end
        repeat (3) begin
          send_word(knob, clip(longint'(aim) + int'($urandom_range(200)) - 100,
                               POS_BOTTOM, POS_TOP),
                    1'b0, aim);
        end
      end
    end
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, manual mode off: the block starts settled with the motor stopped.
    send_word(0, 0, 1'b0, 0);
    // Widest errors in both directions saturate the drive.
    send_word(POT_FULL, POS_BOTTOM, 1'b1, POS_TOP);
    send_word(0, POS_BOTTOM, 1'b0, 0);
    send_word(POT_FULL, POS_TOP, 1'b1, POS_BOTTOM);
    // Zero error, then just under half a degree: settles on the second tick.
    send_word(0, 0, 1'b1, 0);
    send_word(0, 127, 1'b0, 0);
    // Exactly half a degree does not count toward settling.
    send_word(0, 1000 - 128, 1'b1, 1000);
    send_word(0, 1000 + 127, 1'b0, 0);
    send_word(0, 1000 - 127, 1'b0, 0);
    // Tiny drive is raised to the minimum duty.
    send_word(0, -200, 1'b1, 0);
    wait_drained();

    // Manual mode on; writes past the register list must change nothing.
    apply_setting(1, KP_RESET, 0, 0, MIN_DUTY_RESET);
    for (int r = SPARE_REG_LO; r <= SPARE_REG_HI; r++) write_reg(3'(r), $urandom, 0);
    // Full-scale pot step held five ticks jogs the target up a full turn.
    repeat (5) send_word(POT_FULL, 0, 1'b0, 0);
    // A change inside the dead band clears the count.
    send_word(POT_FULL - 5, 0, 1'b0, 0);
    repeat (5) send_word(0, 0, 1'b0, 0);
    // Jog from near the top of the range: the target saturates.
    for (int i = 0; i < 5; i++) send_word(POT_FULL, POS_TOP, i == 0, POS_TOP - 1000);

    for (int blk = 0; blk < SETTINGS; blk++) begin
      wait_drained();
      case (blk)
        0: apply_setting(1, 384, 48, 96, 40);
        1: apply_setting(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, DUTY_MAX);
        2: apply_setting(1, 0, 0, 0, 0);
        3: apply_setting(1, KP_RESET, 0, 0, MIN_DUTY_RESET);
        7: apply_setting($urandom_range(1), $urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                         $urandom_range(16'hFFFF), $urandom_range(DUTY_MAX));
        default: apply_setting($urandom_range(1), $urandom_range(2048), $urandom_range(1024),
                               $urandom_range(1024), $urandom_range(DUTY_MAX));
      endcase
      // Sender eager and receiver stalling, then the reverse, then no idling at all.
      if (blk < 3) begin
        send_idle = 9;
        recv_idle = 53;
      end else if (blk < 6) begin
        send_idle = 53;
        recv_idle = 9;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      run_random(RANDOM_WORDS / SETTINGS);
    end
    wait_drained();

    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mpps_pkg.sv
rtl/mpps_cfg.sv
rtl/mpps_smul.sv
rtl/mpps_jog.sv
rtl/motor_position_pid_step.sv
bench/motor_position_pid_step_checker.sv
bench/motor_position_pid_step_test.sv
